FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files of the run-length encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/rle_pkg.sv
// Shared types and constants of the run-length encoder.
package rle_pkg;

    localparam logic [7:0] PLAIN_RUN_CAP    = 8'd255;
    localparam logic [7:0] IMPROVED_RUN_CAP = 8'd127;
    localparam logic [7:0] IMPROVED_RUN_MIN = 8'd3;

    // command queue between classifier and packer
    localparam int CMD_FIFO_DEPTH = 4;

    localparam int WORD_BYTES = 8;
    localparam int COUNT_W    = 4;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_PAIR,
        CMD_FLUSH,
        CMD_MARK
    } t_cmd_kind;

    // arg0: literal byte, run count or block length
    // arg1: literal store address or run value
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic       mark;
        logic       done;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MFLUSH,
        F_EPAIR,
        F_ELIT0,
        F_EFULL,
        F_ELIT1,
        F_EFLUSH,
        F_MARK
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PAIR,
        B_FLUSH,
        B_MARK
    } t_back_state;

endpackage

FILE: src/rle_literal_run_encoder.sv
// Run-length encoder top level: byte stream in, packed code words out.
// Input: one byte per cycle while the command queue has room; a byte that fills the literal
// store (F_MFLUSH) or ends the stream (F_EPAIR to F_MARK) holds off further input.
// Packer: one code byte per cycle while the output register is free (pair 2 bytes, n literals
// n+1, stored literal 0), plus a mark step per item end; each word passes a pending stage.
// Reset is synchronous, active low: mode returns to plain; the literal RAM is not cleared.
module rle_literal_run_encoder import rle_pkg::*; #(
    parameter int LITERAL_MAX      = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,       // improved_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  logic        i_s_axis_tlast,    // stream_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,    // [63:0] packed_bytes, [67:64] byte_count, zero pad
    output logic        o_m_axis_tuser,    // last_of_item
    output logic        o_m_axis_tlast     // stream_done
);

    logic                    push;
    t_cmd                    push_cmd;
    logic                    q_full;
    logic                    pop;
    logic                    q_valid;
    t_cmd                    q_cmd;
    logic [8*WORD_BYTES-1:0] out_data;
    logic [COUNT_W-1:0]      out_cnt;

    rle_front #(
        .LITERAL_MAX (LITERAL_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_end       (i_s_axis_tlast),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (q_full)
    );

    rle_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rle_back #(
        .LITERAL_MAX      (LITERAL_MAX),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (out_data),
        .o_cnt     (out_cnt),
        .o_last    (o_m_axis_tuser),
        .o_done    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'd0, out_cnt, out_data};

endmodule

FILE: src/rle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rle_cmd_fifo.sv
// Short command queue between the classifier and the packer.
`include "assert_macros.svh"

module rle_cmd_fifo import rle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

    t_cmd          r_mem [CMD_FIFO_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CW'(CMD_FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    `ASSERT_RST(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `ASSERT_RST(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid), "pop from empty queue")

endmodule

FILE: src/rle_front.sv
// Classifier: takes input bytes, tracks runs, lookahead and literal count, issues commands.
`include "assert_macros.svh"

module rle_front import rle_pkg::*; #(
    parameter int LITERAL_MAX = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    localparam int CW = $clog2(LITERAL_MAX + 1);

    t_front_state  r_state, n_state;
    logic          r_mode;
    logic          r_end, n_end;
    logic [CW-1:0] r_lit_cnt, n_lit_cnt;
    logic [7:0]    r_run_val, n_run_val;
    logic [7:0]    r_run_len, n_run_len;
    logic          r_run_open, n_run_open;
    logic [7:0]    r_la0, n_la0;
    logic [7:0]    r_la1, n_la1;
    logic [1:0]    r_la_fill, n_la_fill;

    logic          accept;
    logic          to_la;
    logic          need_mflush;
    logic [CW-1:0] lit_inc;

    function automatic t_cmd mk_cmd(t_cmd_kind kind, logic [7:0] a0, logic [7:0] a1,
                                    logic mark, logic done);
        t_cmd c;
        c.kind = kind;
        c.arg0 = a0;
        c.arg1 = a1;
        c.mark = mark;
        c.done = done;
        return c;
    endfunction

    assign lit_inc = r_lit_cnt + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_end       = r_end;
        n_lit_cnt   = r_lit_cnt;
        n_run_val   = r_run_val;
        n_run_len   = r_run_len;
        n_run_open  = r_run_open;
        n_la0       = r_la0;
        n_la1       = r_la1;
        n_la_fill   = r_la_fill;
        o_push      = 1'b0;
        o_cmd       = mk_cmd(CMD_MARK, 8'd0, 8'd0, 1'b0, 1'b0);
        to_la       = 1'b0;
        need_mflush = 1'b0;
        o_ready     = (r_state == F_IDLE) && !i_full;
        accept      = i_valid && o_ready;

        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_end = i_end;
                    if (!r_mode) begin
                        if (r_run_open && i_byte == r_run_val && r_run_len < PLAIN_RUN_CAP) begin
                            n_run_len = r_run_len + 8'd1;
                            if (n_run_len == PLAIN_RUN_CAP) begin
                                o_push     = 1'b1;
                                o_cmd      = mk_cmd(CMD_PAIR, PLAIN_RUN_CAP, r_run_val,
                                                    !i_end, 1'b0);
                                n_run_open = 1'b0;
                                n_run_len  = 8'd0;
                            end
                        end else begin
                            if (r_run_open) begin
                                o_push = 1'b1;
                                o_cmd  = mk_cmd(CMD_PAIR, r_run_len, r_run_val, !i_end, 1'b0);
                            end
                            n_run_open = 1'b1;
                            n_run_val  = i_byte;
                            n_run_len  = 8'd1;
                        end
                    end else begin
                        if (r_run_open && i_byte == r_run_val
                                && r_run_len < IMPROVED_RUN_CAP) begin
                            n_run_len = r_run_len + 8'd1;
                            if (n_run_len == IMPROVED_RUN_CAP) begin
                                o_push     = 1'b1;
                                o_cmd      = mk_cmd(CMD_PAIR, IMPROVED_RUN_CAP, r_run_val,
                                                    !i_end, 1'b0);
                                n_run_open = 1'b0;
                                n_run_len  = 8'd0;
                            end
                        end else if (r_run_open) begin
                            o_push     = 1'b1;
                            o_cmd      = mk_cmd(CMD_PAIR, r_run_len, r_run_val, !i_end, 1'b0);
                            n_run_open = 1'b0;
                            n_run_len  = 8'd0;
                            to_la      = 1'b1;
                        end else if (r_la_fill != 2'd2) begin
                            to_la = 1'b1;
                        end else if (r_la0 == r_la1 && r_la1 == i_byte) begin
                            // three equal bytes: close the literal block, open a run
                            if (r_lit_cnt != '0) begin
                                o_push = 1'b1;
                                o_cmd  = mk_cmd(CMD_FLUSH, 8'(r_lit_cnt), 8'd0, !i_end, 1'b0);
                            end
                            n_lit_cnt  = '0;
                            n_run_open = 1'b1;
                            n_run_val  = i_byte;
                            n_run_len  = IMPROVED_RUN_MIN;
                            n_la_fill  = 2'd0;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd     = mk_cmd(CMD_LIT, r_la0, 8'(r_lit_cnt), 1'b0, 1'b0);
                            n_la0     = r_la1;
                            n_la1     = i_byte;
                            n_lit_cnt = lit_inc;
                            if (lit_inc == CW'(LITERAL_MAX)) begin
                                need_mflush = 1'b1;
                            end
                        end
                        if (to_la) begin
                            if (r_la_fill == 2'd0) begin
                                n_la0 = i_byte;
                            end else begin
                                n_la1 = i_byte;
                            end
                            n_la_fill = r_la_fill + 2'd1;
                        end
                    end
                    if (need_mflush) begin
                        n_state = F_MFLUSH;
                    end else if (i_end) begin
                        n_state = F_EPAIR;
                    end
                end
            end
            F_MFLUSH: begin
                if (!i_full) begin
                    o_push    = 1'b1;
                    o_cmd     = mk_cmd(CMD_FLUSH, 8'(r_lit_cnt), 8'd0, !r_end, 1'b0);
                    n_lit_cnt = '0;
                    n_state   = r_end ? F_EPAIR : F_IDLE;
                end
            end
            F_EPAIR: begin
                if (!i_full) begin
                    if (r_run_open) begin
                        o_push = 1'b1;
                        o_cmd  = mk_cmd(CMD_PAIR, r_run_len, r_run_val, 1'b0, 1'b0);
                    end
                    n_run_open = 1'b0;
                    n_run_len  = 8'd0;
                    n_state    = r_mode ? F_ELIT0 : F_MARK;
                end
            end
            F_ELIT0: begin
                if (!i_full) begin
                    if (r_la_fill != 2'd0) begin
                        o_push    = 1'b1;
                        o_cmd     = mk_cmd(CMD_LIT, r_la0, 8'(r_lit_cnt), 1'b0, 1'b0);
                        n_lit_cnt = lit_inc;
                    end
                    n_state = F_EFULL;
                end
            end
            F_EFULL: begin
                if (!i_full) begin
                    if (r_lit_cnt == CW'(LITERAL_MAX)) begin
                        o_push    = 1'b1;
                        o_cmd     = mk_cmd(CMD_FLUSH, 8'(r_lit_cnt), 8'd0, 1'b0, 1'b0);
                        n_lit_cnt = '0;
                    end
                    n_state = F_ELIT1;
                end
            end
            F_ELIT1: begin
                if (!i_full) begin
                    if (r_la_fill == 2'd2) begin
                        o_push    = 1'b1;
                        o_cmd     = mk_cmd(CMD_LIT, r_la1, 8'(r_lit_cnt), 1'b0, 1'b0);
                        n_lit_cnt = lit_inc;
                    end
                    n_state = F_EFLUSH;
                end
            end
            F_EFLUSH: begin
                if (!i_full) begin
                    if (r_lit_cnt != '0) begin
                        o_push    = 1'b1;
                        o_cmd     = mk_cmd(CMD_FLUSH, 8'(r_lit_cnt), 8'd0, 1'b0, 1'b0);
                        n_lit_cnt = '0;
                    end
                    n_state = F_MARK;
                end
            end
            F_MARK: begin
                if (!i_full) begin
                    o_push     = 1'b1;
                    o_cmd      = mk_cmd(CMD_MARK, 8'd0, 8'd0, 1'b0, 1'b1);
                    n_lit_cnt  = '0;
                    n_la_fill  = 2'd0;
                    n_run_open = 1'b0;
                    n_run_len  = 8'd0;
                    n_state    = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_mode     <= 1'b0;
            r_end      <= 1'b0;
            r_lit_cnt  <= '0;
            r_run_val  <= 8'd0;
            r_run_len  <= 8'd0;
            r_run_open <= 1'b0;
            r_la_fill  <= 2'd0;
        end else if (i_cfg_we) begin
            // mode change restarts the stream, pending bytes are dropped
            r_state    <= F_IDLE;
            r_mode     <= i_cfg_wdata;
            r_end      <= 1'b0;
            r_lit_cnt  <= '0;
            r_run_val  <= 8'd0;
            r_run_len  <= 8'd0;
            r_run_open <= 1'b0;
            r_la_fill  <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_end      <= n_end;
            r_lit_cnt  <= n_lit_cnt;
            r_run_val  <= n_run_val;
            r_run_len  <= n_run_len;
            r_run_open <= n_run_open;
            r_la_fill  <= n_la_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la0 <= n_la0;
        r_la1 <= n_la1;
    end

    `ASSERT_RST(a_lit_room, i_clk, i_rst_n, !(r_state == F_IDLE) || (r_lit_cnt < CW'(LITERAL_MAX)), "literal store full while idle")
    `ASSERT_RST(a_run_no_la, i_clk, i_rst_n, !(r_mode && r_run_open) || (r_la_fill == 2'd0), "lookahead held during open run")

endmodule

FILE: src/rle_back.sv
// Packer: executes commands, owns the literal store, packs code bytes into result words.
`include "assert_macros.svh"

module rle_back import rle_pkg::*; #(
    parameter int LITERAL_MAX      = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_cmd                    i_q_cmd,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [8*WORD_BYTES-1:0] o_data,
    output logic [COUNT_W-1:0]      o_cnt,
    output logic                    o_last,
    output logic                    o_done
);

    localparam int AW = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
    localparam int CW = $clog2(LITERAL_MAX + 1);
    localparam int DW = 8 * WORD_BYTES;

    t_back_state          r_state, n_state;
    logic [7:0]           r_val, n_val;
    logic                 r_mark, n_mark;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_len, n_len;
    logic [DW-1:0]        r_acc, n_acc;
    logic [COUNT_W-1:0]   r_acc_n, n_acc_n;
    logic                 r_pend_valid, n_pend_valid;
    logic [DW-1:0]        r_pend_data, n_pend_data;
    logic [COUNT_W-1:0]   r_pend_cnt, n_pend_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_out_data, n_out_data;
    logic [COUNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic                 r_out_last, n_out_last;
    logic                 r_out_done, n_out_done;

    logic                 adv;
    logic                 byte_v;
    logic [7:0]           byte_d;
    logic                 unit_last;
    logic                 mark_now;
    logic                 mark_done;
    logic                 word_done;
    logic [DW-1:0]        asm_word;
    logic [COUNT_W-1:0]   acc_inc;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [7:0]           ram_rdata;

    rle_ram #(
        .WIDTH (8),
        .DEPTH (LITERAL_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the whole unit moves only when the output register is free
    assign adv = !r_out_valid || i_ready;

    // command sequencing, one code byte per cycle while the unit moves
    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_mark    = r_mark;
        n_idx     = r_idx;
        n_len     = r_len;
        o_pop     = 1'b0;
        byte_v    = 1'b0;
        byte_d    = 8'd0;
        unit_last = 1'b0;
        mark_now  = 1'b0;
        mark_done = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = i_q_cmd.arg1[AW-1:0];
        ram_wdata = i_q_cmd.arg0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            B_IDLE: begin
                if (adv && i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        CMD_LIT: begin
                            ram_we = 1'b1;
                        end
                        CMD_PAIR: begin
                            byte_v  = 1'b1;
                            byte_d  = i_q_cmd.arg0;
                            n_val   = i_q_cmd.arg1;
                            n_mark  = i_q_cmd.mark;
                            n_state = B_PAIR;
                        end
                        CMD_FLUSH: begin
                            // header is the negated block length
                            byte_v  = 1'b1;
                            byte_d  = 8'd0 - i_q_cmd.arg0;
                            ram_re  = 1'b1;
                            n_idx   = CW'(1);
                            n_len   = i_q_cmd.arg0[CW-1:0];
                            n_mark  = i_q_cmd.mark;
                            n_state = B_FLUSH;
                        end
                        CMD_MARK: begin
                            mark_now  = 1'b1;
                            mark_done = i_q_cmd.done;
                        end
                    endcase
                end
            end
            B_PAIR: begin
                if (adv) begin
                    byte_v    = 1'b1;
                    byte_d    = r_val;
                    unit_last = 1'b1;
                    n_state   = r_mark ? B_MARK : B_IDLE;
                end
            end
            B_FLUSH: begin
                if (adv) begin
                    byte_v = 1'b1;
                    byte_d = ram_rdata;
                    if (r_idx == r_len) begin
                        unit_last = 1'b1;
                        n_state   = r_mark ? B_MARK : B_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx[AW-1:0];
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end
            B_MARK: begin
                if (adv) begin
                    mark_now = 1'b1;
                    n_state  = B_IDLE;
                end
            end
        endcase
    end

    // word assembly, pending word and output register
    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            asm_word[8*k +: 8] = (COUNT_W'(k) == r_acc_n) ? byte_d : r_acc[8*k +: 8];
        end
        acc_inc = r_acc_n + 1'b1;

        n_acc        = r_acc;
        n_acc_n      = r_acc_n;
        word_done    = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_data  = r_pend_data;
        n_pend_cnt   = r_pend_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        if (byte_v) begin
            if (unit_last || acc_inc == COUNT_W'(BYTES_PER_RESULT)) begin
                word_done = 1'b1;
                n_acc     = '0;
                n_acc_n   = '0;
            end else begin
                n_acc   = asm_word;
                n_acc_n = acc_inc;
            end
        end

        // a word waits in the pending stage until it is known whether it ends the item
        if (word_done) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = r_pend_data;
                n_out_cnt   = r_pend_cnt;
                n_out_last  = 1'b0;
                n_out_done  = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_data  = asm_word;
            n_pend_cnt   = acc_inc;
        end

        if (mark_now && r_pend_valid) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_pend_data;
            n_out_cnt    = r_pend_cnt;
            n_out_last   = 1'b1;
            n_out_done   = mark_done;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_mark       <= 1'b0;
            r_acc        <= '0;
            r_acc_n      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mark       <= n_mark;
            r_acc        <= n_acc;
            r_acc_n      <= n_acc_n;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_pend_data <= n_pend_data;
        r_pend_cnt  <= n_pend_cnt;
        r_out_data  <= n_out_data;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_cnt   = r_out_cnt;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;

    `ASSERT_RST(a_mark_aligned, i_clk, i_rst_n, !mark_now || (r_acc_n == '0), "item end inside a partly packed word")
    `ASSERT_RST(a_cnt_range, i_clk, i_rst_n, !r_out_valid || ((r_out_cnt != '0) && (r_out_cnt <= COUNT_W'(BYTES_PER_RESULT))), "result byte count out of range")

endmodule
